### rtl/source_token_scanner_assert.svh
// assertion macros for the token scanner
`ifndef SOURCE_TOKEN_SCANNER_ASSERT_SVH
`define SOURCE_TOKEN_SCANNER_ASSERT_SVH
`ifndef SYNTHESIS
`define STS_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define STS_ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define STS_ASSERT_CLK(label, clk, rst_n, prop)
`define STS_ASSERT_RST(label, clk, rst_n, prop)
`endif
`endif

### rtl/sts_pkg.sv
package sts_pkg;

  localparam int KeywordMaxLen = 8;
  localparam int OffsetWidth = 24;
  localparam int LineWidth = 20;
  localparam int ColWidth = 16;
  localparam int LenWidth = 16;
  localparam int KindWidth = 6;

  localparam logic [KindWidth-1:0] K_EOF = 6'd0;
  localparam logic [KindWidth-1:0] K_IDENT = 6'd1;
  localparam logic [KindWidth-1:0] K_INT = 6'd2;
  localparam logic [KindWidth-1:0] K_STRING = 6'd3;
  localparam logic [KindWidth-1:0] K_PLUS = 6'd4;
  localparam logic [KindWidth-1:0] K_MINUS = 6'd5;
  localparam logic [KindWidth-1:0] K_MINUS_RARROW = 6'd6;
  localparam logic [KindWidth-1:0] K_ASTERISK = 6'd7;
  localparam logic [KindWidth-1:0] K_SLASH = 6'd8;
  localparam logic [KindWidth-1:0] K_BACKSLASH = 6'd9;
  localparam logic [KindWidth-1:0] K_SEMICOLON = 6'd10;
  localparam logic [KindWidth-1:0] K_COLON = 6'd11;
  localparam logic [KindWidth-1:0] K_COLON_COLON = 6'd12;
  localparam logic [KindWidth-1:0] K_DOT = 6'd13;
  localparam logic [KindWidth-1:0] K_DOT_DOT = 6'd14;
  localparam logic [KindWidth-1:0] K_COMMA = 6'd15;
  localparam logic [KindWidth-1:0] K_LARROW = 6'd16;
  localparam logic [KindWidth-1:0] K_LARROW_EQ = 6'd17;
  localparam logic [KindWidth-1:0] K_RARROW = 6'd18;
  localparam logic [KindWidth-1:0] K_RARROW_EQ = 6'd19;
  localparam logic [KindWidth-1:0] K_LPAREN = 6'd20;
  localparam logic [KindWidth-1:0] K_RPAREN = 6'd21;
  localparam logic [KindWidth-1:0] K_LBRACK = 6'd22;
  localparam logic [KindWidth-1:0] K_RBRACK = 6'd23;
  localparam logic [KindWidth-1:0] K_LBRACE = 6'd24;
  localparam logic [KindWidth-1:0] K_RBRACE = 6'd25;
  localparam logic [KindWidth-1:0] K_EQ = 6'd26;
  localparam logic [KindWidth-1:0] K_EQ_EQ = 6'd27;
  localparam logic [KindWidth-1:0] K_EQ_RARROW = 6'd28;
  localparam logic [KindWidth-1:0] K_AT = 6'd29;
  localparam logic [KindWidth-1:0] K_UNKNOWN = 6'd30;
  // keyword kinds, in table order from K_LET up
  localparam logic [KindWidth-1:0] K_LET = 6'd31;
  localparam logic [KindWidth-1:0] K_MUT = 6'd32;
  localparam logic [KindWidth-1:0] K_IF = 6'd33;
  localparam logic [KindWidth-1:0] K_ELSE = 6'd34;
  localparam logic [KindWidth-1:0] K_STRUCT = 6'd35;
  localparam logic [KindWidth-1:0] K_WHILE = 6'd36;
  localparam logic [KindWidth-1:0] K_RETURN = 6'd37;
  localparam logic [KindWidth-1:0] K_BREAK = 6'd38;
  localparam logic [KindWidth-1:0] K_PUB = 6'd39;
  localparam logic [KindWidth-1:0] K_TEST = 6'd40;
  localparam logic [KindWidth-1:0] K_THEN = 6'd41;
  localparam logic [KindWidth-1:0] K_TRUE = 6'd42;
  localparam logic [KindWidth-1:0] K_CONST = 6'd43;
  localparam logic [KindWidth-1:0] K_CONTINUE = 6'd44;
  localparam logic [KindWidth-1:0] K_FUNC = 6'd45;
  localparam logic [KindWidth-1:0] K_FOR = 6'd46;
  localparam logic [KindWidth-1:0] K_FALSE = 6'd47;

  typedef enum logic [5:0] {
    M_IDLE    = 6'b000001,
    M_IDENT   = 6'b000010,
    M_INT     = 6'b000100,
    M_STRING  = 6'b001000,
    M_OPER    = 6'b010000,
    M_COMMENT = 6'b100000
  } mode_t;

  function automatic logic [KindWidth-1:0] single_op_kind(input logic [7:0] c);
    logic [KindWidth-1:0] k;
    begin
      case (c)
        "+": k = K_PLUS;       "-": k = K_MINUS;      "*": k = K_ASTERISK;
        "/": k = K_SLASH;      "\\": k = K_BACKSLASH; ";": k = K_SEMICOLON;
        ":": k = K_COLON;      ".": k = K_DOT;        ",": k = K_COMMA;
        "<": k = K_LARROW;     ">": k = K_RARROW;     "(": k = K_LPAREN;
        ")": k = K_RPAREN;     "[": k = K_LBRACK;     "]": k = K_RBRACK;
        "{": k = K_LBRACE;     "}": k = K_RBRACE;     "=": k = K_EQ;
        "@": k = K_AT;
        default: k = K_UNKNOWN;
      endcase
      return k;
    end
  endfunction

  function automatic logic [KindWidth-1:0] pair_kind(input logic [7:0] p,
                                                     input logic [7:0] c);
    logic [KindWidth-1:0] k;
    begin
      k = K_EOF;
      if (p == "-" && c == ">") k = K_MINUS_RARROW;
      if (p == ":" && c == ":") k = K_COLON_COLON;
      if (p == "." && c == ".") k = K_DOT_DOT;
      if (p == "<" && c == "=") k = K_LARROW_EQ;
      if (p == ">" && c == "=") k = K_RARROW_EQ;
      if (p == "=" && c == "=") k = K_EQ_EQ;
      if (p == "=" && c == ">") k = K_EQ_RARROW;
      return k;
    end
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_pair_lead(input logic [7:0] c);
    return c == "/" || c == "-" || c == ":" || c == "." || c == "<" ||
           c == ">" || c == "=";
  endfunction

endpackage

### rtl/sts_keyword_match.sv
// parallel keyword compare over the first eight identifier bytes
module sts_keyword_match (
  input  logic [8*8-1:0]                pfx,
  input  logic [sts_pkg::LenWidth-1:0]  len,
  output logic [sts_pkg::KindWidth-1:0] kind
);

  // keyword text left aligned in 64 bits
  function automatic logic hit(input logic [63:0] p, input logic [63:0] kw,
                               input int n);
    logic ok;
    begin
      ok = 1'b1;
      for (int i = 0; i < 8; i++) begin
        if (i < n && p[8*i +: 8] != kw[8*(7-i) +: 8]) ok = 1'b0;
      end
      return ok;
    end
  endfunction

  always_comb begin
    kind = sts_pkg::K_IDENT;
    case (len)
      16'd2: if (hit(pfx, {"if", 48'd0}, 2)) kind = sts_pkg::K_IF;
      16'd3: begin
        if (hit(pfx, {"let", 40'd0}, 3)) kind = sts_pkg::K_LET;
        if (hit(pfx, {"mut", 40'd0}, 3)) kind = sts_pkg::K_MUT;
        if (hit(pfx, {"pub", 40'd0}, 3)) kind = sts_pkg::K_PUB;
        if (hit(pfx, {"for", 40'd0}, 3)) kind = sts_pkg::K_FOR;
      end
      16'd4: begin
        if (hit(pfx, {"else", 32'd0}, 4)) kind = sts_pkg::K_ELSE;
        if (hit(pfx, {"test", 32'd0}, 4)) kind = sts_pkg::K_TEST;
        if (hit(pfx, {"then", 32'd0}, 4)) kind = sts_pkg::K_THEN;
        if (hit(pfx, {"true", 32'd0}, 4)) kind = sts_pkg::K_TRUE;
        if (hit(pfx, {"func", 32'd0}, 4)) kind = sts_pkg::K_FUNC;
      end
      16'd5: begin
        if (hit(pfx, {"while", 24'd0}, 5)) kind = sts_pkg::K_WHILE;
        if (hit(pfx, {"break", 24'd0}, 5)) kind = sts_pkg::K_BREAK;
        if (hit(pfx, {"const", 24'd0}, 5)) kind = sts_pkg::K_CONST;
        if (hit(pfx, {"false", 24'd0}, 5)) kind = sts_pkg::K_FALSE;
      end
      16'd6: begin
        if (hit(pfx, {"struct", 16'd0}, 6)) kind = sts_pkg::K_STRUCT;
        if (hit(pfx, {"return", 16'd0}, 6)) kind = sts_pkg::K_RETURN;
      end
      16'd8: if (hit(pfx, "continue", 8)) kind = sts_pkg::K_CONTINUE;
      default: kind = sts_pkg::K_IDENT;
    endcase
  end

endmodule

### rtl/source_token_scanner.sv
// output: a token is registered onto out_ at the edge that accepts the byte that ends it
// throughput: one byte per cycle while out_ is not stalled; a byte that makes two tokens
// holds in_tready low until the first token is taken and the second leaves the holding slot
// reset: rst_n synchronous active low clears mode, position and output valid
module source_token_scanner #(
  parameter int OFFSET_WIDTH = sts_pkg::OffsetWidth,
  parameter int LINE_WIDTH   = sts_pkg::LineWidth,
  parameter int COL_WIDTH    = sts_pkg::ColWidth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,  // char_byte
  input  logic        in_tuser,  // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  // token_kind, token_offset, token_length, token_line, token_col, zero fill
  output logic [((6+OFFSET_WIDTH+16+LINE_WIDTH+COL_WIDTH+7)/8)*8-1:0] out_tdata,
  output logic        out_tlast
);
  `include "source_token_scanner_assert.svh"

  localparam int OW = OFFSET_WIDTH;
  localparam int LW = LINE_WIDTH;
  localparam int CW = COL_WIDTH;
  localparam int TW = 6 + OW + 16 + LW + CW;
  localparam int DW = ((TW + 7) / 8) * 8;
  localparam logic [15:0] KwMax = 16'(sts_pkg::KeywordMaxLen);

  typedef struct packed {
    logic [CW-1:0] col;
    logic [LW-1:0] line;
    logic [15:0]   len;
    logic [OW-1:0] off;
    logic [5:0]    kind;
  } tok_t;

  sts_pkg::mode_t mode_r, mode_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [63:0] pfx_r, pfx_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [OW-1:0] soff_r, soff_nxt, pos_r, pos_nxt;
  logic [LW-1:0] sline_r, sline_nxt, line_r, line_nxt;
  logic [CW-1:0] scol_r, scol_nxt, col_r, col_nxt;

  // output register plus one holding slot for a second token
  logic   o_vld_r, o_vld_nxt, h_vld_r, h_vld_nxt;
  tok_t   o_tok_r, o_tok_nxt, h_tok_r, h_tok_nxt;
  logic   o_last_r, o_last_nxt;

  logic [5:0] kw_kind;
  sts_keyword_match u_kw (.pfx(pfx_r), .len(cnt_r), .kind(kw_kind));

  logic acc;
  assign in_tready = !h_vld_r && (!o_vld_r || out_tready);
  assign acc = in_tvalid && in_tready;

  logic [1:0] n;
  tok_t t0, t1;
  logic [7:0] c;
  logic eoi;

  function automatic tok_t mk(input logic [5:0] k, input logic [OW-1:0] o,
                              input logic [15:0] l, input logic [LW-1:0] ln,
                              input logic [CW-1:0] cl);
    tok_t t;
    begin
      t.kind = k; t.off = o; t.len = l; t.line = ln; t.col = cl;
      return t;
    end
  endfunction

  always_comb begin
    logic fresh, adv_col, adv_nl;
    logic [5:0] pk, pkind;
    tok_t tk;
    c = in_tdata;
    eoi = in_tuser || (in_tdata == 8'd0);
    mode_nxt = mode_r; pend_nxt = pend_r; pfx_nxt = pfx_r; cnt_nxt = cnt_r;
    soff_nxt = soff_r; sline_nxt = sline_r; scol_nxt = scol_r;
    pos_nxt = pos_r; line_nxt = line_r; col_nxt = col_r;
    n = 2'd0; t0 = '0; t1 = '0;
    fresh = 1'b0; adv_col = 1'b0; adv_nl = 1'b0;
    pk = sts_pkg::pair_kind(pend_r, c);
    // the pending token as a flush would emit it
    pkind = sts_pkg::K_IDENT;
    unique case (mode_r)
      sts_pkg::M_IDENT:  pkind = (cnt_r > KwMax) ? sts_pkg::K_IDENT : kw_kind;
      sts_pkg::M_INT:    pkind = sts_pkg::K_INT;
      sts_pkg::M_STRING: pkind = sts_pkg::K_STRING;
      sts_pkg::M_OPER:   pkind = sts_pkg::single_op_kind(pend_r);
      default:           pkind = sts_pkg::K_IDENT;
    endcase
    tk = mk(pkind, soff_r, (mode_r == sts_pkg::M_OPER) ? 16'd1 : cnt_r,
            sline_r, scol_r);
    if (eoi) begin
      if (mode_r != sts_pkg::M_IDLE && mode_r != sts_pkg::M_COMMENT) begin
        t0 = tk; t1 = mk(sts_pkg::K_EOF, pos_r, 16'd0, line_r, col_r);
        n = 2'd2;
      end else begin
        t0 = mk(sts_pkg::K_EOF, pos_r, 16'd0, line_r, col_r);
        n = 2'd1;
      end
      mode_nxt = sts_pkg::M_IDLE; cnt_nxt = '0;
    end else begin
      unique case (mode_r)
        sts_pkg::M_IDENT: begin
          if (sts_pkg::is_alpha(c) || sts_pkg::is_digit(c)) begin
            if (cnt_r < KwMax) pfx_nxt[8*cnt_r[2:0] +: 8] = c;
            if (cnt_r != 16'hFFFF) cnt_nxt = cnt_r + 16'd1;
            adv_col = 1'b1;
          end else begin
            t0 = tk; n = 2'd1; fresh = 1'b1;
          end
        end
        sts_pkg::M_INT: begin
          if (sts_pkg::is_digit(c)) begin
            if (cnt_r != 16'hFFFF) cnt_nxt = cnt_r + 16'd1;
            adv_col = 1'b1;
          end else begin
            t0 = tk; n = 2'd1; fresh = 1'b1;
          end
        end
        sts_pkg::M_STRING: begin
          if (c == "\"") begin
            t0 = tk; n = 2'd1; mode_nxt = sts_pkg::M_IDLE; cnt_nxt = '0;
          end else if (cnt_r != 16'hFFFF) cnt_nxt = cnt_r + 16'd1;
          adv_col = 1'b1;
        end
        sts_pkg::M_COMMENT: begin
          if (c == "\n") begin
            mode_nxt = sts_pkg::M_IDLE; adv_nl = 1'b1;
          end else adv_col = 1'b1;
        end
        sts_pkg::M_OPER: begin
          if (pend_r == "/" && c == "/") begin
            mode_nxt = sts_pkg::M_COMMENT; adv_col = 1'b1;
          end else if (pk != sts_pkg::K_EOF) begin
            t0 = mk(pk, soff_r, 16'd2, sline_r, scol_r); n = 2'd1;
            mode_nxt = sts_pkg::M_IDLE; adv_col = 1'b1;
          end else begin
            t0 = tk; n = 2'd1; fresh = 1'b1;
          end
        end
        default: fresh = 1'b1;
      endcase
      if (fresh) begin
        mode_nxt = sts_pkg::M_IDLE; cnt_nxt = '0;
        // space, tab and carriage return
        if (c == " " || c == "\t" || c == 8'h0D) adv_col = 1'b1;
        else if (c == "\n") adv_nl = 1'b1;
        else begin
          adv_col = 1'b1;
          soff_nxt = pos_r; sline_nxt = line_r; scol_nxt = col_r;
          if (sts_pkg::is_alpha(c) || sts_pkg::is_digit(c)) begin
            mode_nxt = sts_pkg::is_alpha(c) ? sts_pkg::M_IDENT : sts_pkg::M_INT;
            pfx_nxt[7:0] = c; cnt_nxt = 16'd1;
          end else if (c == "\"") begin
            // string content starts after the quote
            soff_nxt = (pos_r == '1) ? pos_r : pos_r + 1'b1;
            scol_nxt = (col_r == '1) ? col_r : col_r + 1'b1;
            mode_nxt = sts_pkg::M_STRING;
          end else if (sts_pkg::is_pair_lead(c)) begin
            mode_nxt = sts_pkg::M_OPER; pend_nxt = c;
          end else begin
            if (n == 2'd0) begin
              t0 = mk(sts_pkg::single_op_kind(c), pos_r, 16'd1, line_r, col_r);
              n = 2'd1;
            end else begin
              t1 = mk(sts_pkg::single_op_kind(c), pos_r, 16'd1, line_r, col_r);
              n = 2'd2;
            end
          end
        end
      end
      if (adv_col || adv_nl) begin
        pos_nxt = (pos_r == '1) ? pos_r : pos_r + 1'b1;
        if (adv_nl) begin
          line_nxt = (line_r == '1) ? line_r : line_r + 1'b1;
          col_nxt = '0;
        end else col_nxt = (col_r == '1) ? col_r : col_r + 1'b1;
      end
    end
  end

  always_comb begin
    o_vld_nxt = o_vld_r; o_tok_nxt = o_tok_r; o_last_nxt = o_last_r;
    h_vld_nxt = h_vld_r; h_tok_nxt = h_tok_r;
    if (o_vld_r && out_tready) begin
      o_vld_nxt = h_vld_r; o_tok_nxt = h_tok_r; o_last_nxt = 1'b1;
      h_vld_nxt = 1'b0;
    end
    if (acc && n != 2'd0) begin
      o_vld_nxt = 1'b1; o_tok_nxt = t0; o_last_nxt = (n == 2'd1);
      h_vld_nxt = (n == 2'd2); h_tok_nxt = t1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sts_pkg::M_IDLE; pend_r <= '0; cnt_r <= '0;
      soff_r <= '0; sline_r <= '0; scol_r <= '0;
      pos_r <= '0; line_r <= '0; col_r <= '0;
      o_vld_r <= 1'b0; h_vld_r <= 1'b0;
    end else begin
      if (acc) begin
        mode_r <= mode_nxt; pend_r <= pend_nxt; cnt_r <= cnt_nxt;
        soff_r <= soff_nxt; sline_r <= sline_nxt; scol_r <= scol_nxt;
        pos_r <= pos_nxt; line_r <= line_nxt; col_r <= col_nxt;
      end
      o_vld_r <= o_vld_nxt; h_vld_r <= h_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) pfx_r <= pfx_nxt;
    o_tok_r <= o_tok_nxt; h_tok_r <= h_tok_nxt; o_last_r <= o_last_nxt;
  end

  assign out_tvalid = o_vld_r;
  assign out_tlast = o_last_r;
  assign out_tdata = {{(DW-TW){1'b0}}, o_tok_r};

  `STS_ASSERT_CLK(a_hold_needs_out, clk, rst_n, h_vld_r |-> o_vld_r)
  `STS_ASSERT_CLK(a_hold_blocks_in, clk, rst_n, h_vld_r |-> !in_tready)
  `STS_ASSERT_CLK(a_hold_not_last, clk, rst_n, h_vld_r |-> !o_last_r)
  `STS_ASSERT_RST(a_reset_clears, clk, rst_n, !rst_n |=> !o_vld_r && !h_vld_r)

endmodule
